/* rtl/core/qbd_pkg.sv */
`timescale 1ns / 1ps

package qbd_pkg;

  localparam int unsigned CountW = 12;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [7:0] ChEquals     = 8'h3d;
  localparam logic [7:0] ChUnderscore = 8'h5f;
  localparam logic [7:0] ChNewline    = 8'h0a;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] EndByteReset = 8'h3f;

  // configuration register indexes
  localparam logic CfgDecodeMode = 1'b0;
  localparam logic CfgEndByte    = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_NORMAL   = 2'd0,
    PH_AFTER_EQ = 2'd1,
    PH_HEX_OK   = 2'd2,
    PH_HEX_BAD  = 2'd3
  } phase_e;

  typedef enum logic {
    OP_DATA  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        out_byte;
    logic [CountW-1:0] chunk_count;
  } out_item_t;

  typedef struct packed {
    logic       decode_mode;
    logic [7:0] end_byte;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } rank_t;

  function automatic hex_t hex_value(logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.ok  = 1'b1;
      r.val = 4'(c - 8'h57);
    end
    return r;
  endfunction

  function automatic rank_t b64_rank(logic [7:0] c);
    rank_t r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.ok  = 1'b1;
      r.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.ok  = 1'b1;
      r.val = 6'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 6'(c + 8'h04);
    end else if (c == 8'h2b) begin
      r.ok  = 1'b1;
      r.val = 6'd62;
    end else if (c == 8'h2f) begin
      r.ok  = 1'b1;
      r.val = 6'd63;
    end
    return r;
  endfunction

endpackage

/* rtl/core/qbd_decode.sv */
`timescale 1ns / 1ps

module qbd_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  qbd_pkg::in_item_t  item_i,
  input  qbd_pkg::cfg_t      cfg_i,
  output logic               has_res_o,
  output qbd_pkg::out_item_t res_o
);

  qbd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  nibble_q, nibble_d;
  logic        drop_q, drop_d;
  logic [11:0] pool_q, pool_d;
  logic [3:0]  bits_q, bits_d;
  logic [qbd_pkg::CountW-1:0] total_q, total_d;

  qbd_pkg::hex_t  hex;
  qbd_pkg::rank_t rank;
  logic [qbd_pkg::CountW-1:0] total_inc;
  logic [11:0] pool_shift;
  logic [3:0]  bits_add;
  logic [3:0]  shamt;

  always_comb begin
    hex        = qbd_pkg::hex_value(item_i.in_byte);
    rank       = qbd_pkg::b64_rank(item_i.in_byte);
    total_inc  = (total_q == qbd_pkg::CountMax) ? total_q : total_q + 1'b1;
    pool_shift = {pool_q[5:0], rank.val};
    bits_add   = bits_q + 4'd6;
    shamt      = bits_add - 4'd8;

    phase_d   = phase_q;
    nibble_d  = nibble_q;
    drop_d    = drop_q;
    pool_d    = pool_q;
    bits_d    = bits_q;
    total_d   = total_q;
    has_res_o = 1'b0;
    res_o     = '0;

    if (item_i.op == qbd_pkg::OP_FLUSH) begin
      pool_d = '0;
      bits_d = '0;
    end else if (item_i.in_byte == cfg_i.end_byte) begin
      phase_d  = qbd_pkg::PH_NORMAL;
      nibble_d = '0;
      drop_d   = 1'b0;
      total_d  = '0;
      if (!drop_q) begin
        has_res_o         = 1'b1;
        res_o.chunk_count = total_q;
        res_o.kind        = (!cfg_i.decode_mode && phase_q != qbd_pkg::PH_NORMAL) ?
                            qbd_pkg::KIND_ERR : qbd_pkg::KIND_END;
      end
    end else if (drop_q) begin
      // discard until the delimiter
    end else if (!cfg_i.decode_mode) begin
      unique case (phase_q)
        qbd_pkg::PH_NORMAL: begin
          if (item_i.in_byte == qbd_pkg::ChEquals) begin
            phase_d = qbd_pkg::PH_AFTER_EQ;
          end else begin
            has_res_o         = 1'b1;
            total_d           = total_inc;
            res_o.kind        = qbd_pkg::KIND_BYTE;
            res_o.chunk_count = total_inc;
            res_o.out_byte    = (item_i.in_byte == qbd_pkg::ChUnderscore &&
                                 cfg_i.end_byte != 8'd0) ? qbd_pkg::ChSpace :
                                item_i.in_byte;
          end
        end
        qbd_pkg::PH_AFTER_EQ: begin
          if (item_i.in_byte == qbd_pkg::ChNewline) begin
            phase_d = qbd_pkg::PH_NORMAL;
          end else if (hex.ok) begin
            nibble_d = hex.val;
            phase_d  = qbd_pkg::PH_HEX_OK;
          end else begin
            nibble_d = '0;
            phase_d  = qbd_pkg::PH_HEX_BAD;
          end
        end
        qbd_pkg::PH_HEX_OK, qbd_pkg::PH_HEX_BAD: begin
          phase_d   = qbd_pkg::PH_NORMAL;
          nibble_d  = '0;
          has_res_o = 1'b1;
          if (hex.ok && phase_q == qbd_pkg::PH_HEX_OK) begin
            total_d           = total_inc;
            res_o.kind        = qbd_pkg::KIND_BYTE;
            res_o.chunk_count = total_inc;
            res_o.out_byte    = {nibble_q, hex.val};
          end else begin
            drop_d            = 1'b1;
            res_o.kind        = qbd_pkg::KIND_ERR;
            res_o.chunk_count = total_q;
          end
        end
        default: ;
      endcase
    end else if (rank.ok) begin
      pool_d = pool_shift;
      bits_d = bits_add;
      // pool never holds more than six spare bits, so a byte is ready at eight or more
      if (bits_add >= 4'd8) begin
        bits_d            = shamt;
        has_res_o         = 1'b1;
        total_d           = total_inc;
        res_o.kind        = qbd_pkg::KIND_BYTE;
        res_o.chunk_count = total_inc;
        res_o.out_byte    = 8'(pool_shift >> shamt);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= qbd_pkg::PH_NORMAL;
      nibble_q <= '0;
      drop_q   <= 1'b0;
      pool_q   <= '0;
      bits_q   <= '0;
      total_q  <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      nibble_q <= nibble_d;
      drop_q   <= drop_d;
      pool_q   <= pool_d;
      bits_q   <= bits_d;
      total_q  <= total_d;
    end
  end

endmodule

/* rtl/core/qbd_out_reg.sv */
`timescale 1ns / 1ps

module qbd_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  qbd_pkg::out_item_t data_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qbd_pkg::out_item_t out_data_o
);

  logic               valid_q;
  qbd_pkg::out_item_t data_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

/* rtl/core/qp_and_base64_chunk_decoder.sv */
`timescale 1ns / 1ps

// Chunked Q (quoted-printable) / B (base64) decoder. One encoded byte or flush
// transfer is taken every clock while no result is held back; each item passes an
// input register and one level of decode logic, and a result is then stored in a
// result register. Throughput is one item per cycle while results are taken. An item
// that yields no result moves on even while the result register is stalled; one that
// yields a result waits only for that register. Configuration writes are always
// accepted and should be made only while the block is idle.
module qp_and_base64_chunk_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  qbd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output qbd_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  qbd_pkg::cfg_t      cfg_q;
  logic               in_valid_q;
  qbd_pkg::in_item_t  in_item_q;
  logic               has_res;
  qbd_pkg::out_item_t res;
  logic               out_free;
  logic               advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decode_mode <= 1'b0;
      cfg_q.end_byte    <= qbd_pkg::EndByteReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        qbd_pkg::CfgDecodeMode: cfg_q.decode_mode <= cfg_data_i[0];
        qbd_pkg::CfgEndByte:    cfg_q.end_byte    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // results need a free result slot; silent items always drain
  assign advance    = in_valid_q && (!has_res || out_free);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_data_i;
    end
  end

  qbd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg_q),
    .has_res_o (has_res),
    .res_o     (res)
  );

  qbd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && has_res),
    .data_i      (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_kind_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.kind == qbd_pkg::KIND_BYTE ||
                     out_data_o.kind == qbd_pkg::KIND_END ||
                     out_data_o.kind == qbd_pkg::KIND_ERR))
    else $error("result kind out of range");

  a_byte_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == qbd_pkg::KIND_BYTE) |->
      out_data_o.chunk_count != '0)
    else $error("decoded byte with zero chunk count");

  a_stall_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_valid_q && has_res && out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_flush_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_item_q.op == qbd_pkg::OP_FLUSH) |-> !has_res)
    else $error("flush produced a result");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;

  logic               enc_valid = 1'b0;
  logic               enc_ready;
  qbd_pkg::in_item_t  enc_item = '0;
  logic               dec_valid;
  logic               dec_ready = 1'b0;
  qbd_pkg::out_item_t dec_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = qbd_pkg::CfgDecodeMode;
  logic [7:0]         cfg_data = '0;

  qp_and_base64_chunk_decoder DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (enc_valid),
    .in_ready_o  (enc_ready),
    .in_data_i   (enc_item),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_data_o  (dec_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 0;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // encoded items waiting for the driver, decoded results waiting for the monitor
  qbd_pkg::in_item_t  encoded_q[$];
  qbd_pkg::out_item_t decoded_q[$];
  int        queued_cnt = 0;
  int        taken_cnt = 0;
  int        fail_cnt = 0;

  // decoder state as the testbench sees it
  logic            mode_b64 = 1'b0;
  logic [7:0]      delim = qbd_pkg::EndByteReset;
  qbd_pkg::phase_e esc_phase = qbd_pkg::PH_NORMAL;
  logic [3:0]      esc_high = '0;
  logic            dropping = 1'b0;
  logic [11:0]     pool = '0;
  logic [3:0]      pool_fill = '0;
  logic [11:0]     chunk_total = '0;

  // bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return {1'b1, c[3:0]};
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  // bit 6 flags a base64 symbol, bits 5:0 hold its rank
  function automatic logic [6:0] b64_symbol(input logic [7:0] c);
    logic [7:0] r;
    r = '0;
    if (c inside {[8'h41:8'h5a]}) r = c - 8'h41;
    else if (c inside {[8'h61:8'h7a]}) r = c - 8'h61 + 8'd26;
    else if (c inside {[8'h30:8'h39]}) r = c - 8'h30 + 8'd52;
    else if (c == "+") r = 8'd62;
    else if (c == "/") r = 8'd63;
    else return 7'd0;
    return {1'b1, r[5:0]};
  endfunction

  function automatic void queue_result(input qbd_pkg::kind_e k, input logic [7:0] b,
                                       input logic [11:0] n);
    qbd_pkg::out_item_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.chunk_count = n;
    decoded_q.push_back(r);
  endfunction

  function automatic void emit_decoded(input logic [7:0] b);
    if (chunk_total != qbd_pkg::CountMax) chunk_total = chunk_total + 12'd1;
    queue_result(qbd_pkg::KIND_BYTE, b, chunk_total);
  endfunction

  function automatic void decode_item(input qbd_pkg::in_item_t it);
    logic [7:0]  c;
    logic [4:0]  hx;
    logic [6:0]  sym;
    logic [11:0] cnt;
    logic        was_drop;
    logic        open_esc;
    logic [3:0]  hi;
    logic [4:0]  sum;
    logic [11:0] shifted;
    c  = it.in_byte;
    hx = hex_digit(c);
    if (it.op == qbd_pkg::OP_FLUSH) begin
      pool      = '0;
      pool_fill = '0;
    end else if (c == delim) begin
      cnt         = chunk_total;
      was_drop    = dropping;
      open_esc    = !mode_b64 && esc_phase != qbd_pkg::PH_NORMAL;
      esc_phase   = qbd_pkg::PH_NORMAL;
      esc_high    = '0;
      dropping    = 1'b0;
      chunk_total = '0;
      if (!was_drop) begin
        queue_result(open_esc ? qbd_pkg::KIND_ERR : qbd_pkg::KIND_END, 8'h00, cnt);
      end
    end else if (dropping) begin
      // discard until the delimiter
    end else if (!mode_b64) begin
      case (esc_phase)
        qbd_pkg::PH_NORMAL: begin
          if (c == qbd_pkg::ChEquals) esc_phase = qbd_pkg::PH_AFTER_EQ;
          else if (c == qbd_pkg::ChUnderscore && delim != 8'h00) begin
            emit_decoded(qbd_pkg::ChSpace);
          end
          else emit_decoded(c);
        end
        qbd_pkg::PH_AFTER_EQ: begin
          if (c == qbd_pkg::ChNewline) begin
            esc_phase = qbd_pkg::PH_NORMAL;
          end else if (hx[4]) begin
            esc_high  = hx[3:0];
            esc_phase = qbd_pkg::PH_HEX_OK;
          end else begin
            esc_high  = '0;
            esc_phase = qbd_pkg::PH_HEX_BAD;
          end
        end
        default: begin
          hi        = esc_high;
          open_esc  = hx[4] && esc_phase == qbd_pkg::PH_HEX_OK;
          esc_phase = qbd_pkg::PH_NORMAL;
          esc_high  = '0;
          if (open_esc) begin
            emit_decoded({hi, hx[3:0]});
          end else begin
            dropping = 1'b1;
            queue_result(qbd_pkg::KIND_ERR, 8'h00, chunk_total);
          end
        end
      endcase
    end else begin
      sym = b64_symbol(c);
      if (sym[6]) begin
        pool = {pool[5:0], sym[5:0]};
        sum  = {1'b0, pool_fill} + 5'd6;
        if (sum >= 5'd8 && sum <= 5'd12) begin
          shifted   = pool >> (sum - 5'd8);
          pool_fill = 4'(sum - 5'd8);
          emit_decoded(shifted[7:0]);
        end else begin
          pool_fill = sum[3:0];
        end
      end
    end
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (enc_valid && enc_ready) begin
        decode_item(enc_item);
        taken_cnt++;
      end
      if (!enc_valid || enc_ready) begin
        if (gap_left > 0 || encoded_q.size() == 0) begin
          enc_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          enc_item  <= encoded_q.pop_front();
          enc_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: a stall pattern redrawn at random as rx_cycle advances; a hold request stalls it outright
  logic rx_hold_req = 1'b0;
  int   rx_hold_left = 0;
  int   rx_cycle = 0;
  int   rx_style = 0;

  task automatic check_result(input qbd_pkg::out_item_t got);
    qbd_pkg::out_item_t want;
    if (decoded_q.size() == 0) begin
      $error("transfer with nothing outstanding: kind %0d byte %02h count %0d",
             got.kind, got.out_byte, got.chunk_count);
      fail_cnt++;
    end else begin
      want = decoded_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        fail_cnt++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
        fail_cnt++;
      end
      if (got.chunk_count !== want.chunk_count) begin
        $error("chunk_count: expected %0d, got %0d", want.chunk_count, got.chunk_count);
        fail_cnt++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (dec_valid && dec_ready) check_result(dec_item);
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 3);
      if (rx_hold_req) begin
        rx_hold_left = 400;
        rx_hold_req  = 1'b0;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        dec_ready <= 1'b0;
      end else begin
        case (rx_style)
          0:       dec_ready <= 1'b1;
          1:       dec_ready <= 1'($urandom_range(0, 1));
          2:       dec_ready <= (rx_cycle % 3) == 0;
          default: dec_ready <= (rx_cycle % 16) > 4;
        endcase
      end
    end
  end

  task automatic push_item(input qbd_pkg::op_e op, input logic [7:0] b);
    qbd_pkg::in_item_t it;
    it.op      = op;
    it.in_byte = b;
    encoded_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == qbd_pkg::CfgDecodeMode) mode_b64 = val[0];
    else delim = val;
  endtask

  // hold until every transfer is taken and answered, then let the pipeline drain
  task automatic wait_idle();
    while (taken_cnt != queued_cnt || decoded_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + v;
    if (v < 6'd52) return 8'h61 + v - 8'd26;
    if (v < 6'd62) return 8'h30 + v - 8'd52;
    return (v == 6'd62) ? "+" : "/";
  endfunction

  task automatic q_chunk(input int len);
    repeat (len) begin
      case ($urandom_range(0, 19))
        0, 1: push_item(qbd_pkg::OP_DATA, 8'($urandom_range(0, 255)));
        2:    push_item(qbd_pkg::OP_DATA, qbd_pkg::ChUnderscore);
        3, 4, 5: begin
          push_item(qbd_pkg::OP_DATA, qbd_pkg::ChEquals);
          push_item(qbd_pkg::OP_DATA, hex_char(4'($urandom_range(0, 15))));
          push_item(qbd_pkg::OP_DATA, hex_char(4'($urandom_range(0, 15))));
        end
        6: begin
          push_item(qbd_pkg::OP_DATA, qbd_pkg::ChEquals);
          push_item(qbd_pkg::OP_DATA, qbd_pkg::ChNewline);
        end
        7: begin
          push_item(qbd_pkg::OP_DATA, qbd_pkg::ChEquals);
          push_item(qbd_pkg::OP_DATA, 8'($urandom_range(0, 255)));
          push_item(qbd_pkg::OP_DATA, 8'($urandom_range(0, 255)));
        end
        8:       push_item(qbd_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
        default: push_item(qbd_pkg::OP_DATA, 8'($urandom_range(8'h20, 8'h7e)));
      endcase
    end
    if ($urandom_range(0, 9) != 0) push_item(qbd_pkg::OP_DATA, delim);
  endtask

  task automatic b_chunk(input int len);
    repeat (len) begin
      case ($urandom_range(0, 15))
        0:       push_item(qbd_pkg::OP_DATA, 8'($urandom_range(0, 255)));
        1:       push_item(qbd_pkg::OP_DATA, qbd_pkg::ChEquals);
        2:       push_item(qbd_pkg::OP_FLUSH, 8'($urandom_range(0, 255)));
        default: push_item(qbd_pkg::OP_DATA, b64_char(6'($urandom_range(0, 63))));
      endcase
    end
    if ($urandom_range(0, 9) != 0) push_item(qbd_pkg::OP_DATA, delim);
  endtask

  initial begin
    int         base;
    int         phase_no;
    logic       m;
    logic [7:0] d;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Q mode at reset settings: plain, underscore, byte extremes, escapes, soft break
    push_item(qbd_pkg::OP_DATA, "A");
    push_item(qbd_pkg::OP_DATA, qbd_pkg::ChUnderscore);
    push_item(qbd_pkg::OP_DATA, 8'h00);
    push_item(qbd_pkg::OP_DATA, 8'hff);
    push_item(qbd_pkg::OP_DATA, qbd_pkg::ChEquals);
    push_item(qbd_pkg::OP_DATA, "4");
    push_item(qbd_pkg::OP_DATA, "1");
    push_item(qbd_pkg::OP_DATA, qbd_pkg::ChEquals);
    push_item(qbd_pkg::OP_DATA, qbd_pkg::ChNewline);
    push_item(qbd_pkg::OP_DATA, qbd_pkg::ChEquals);
    push_item(qbd_pkg::OP_DATA, "f");
    push_item(qbd_pkg::OP_DATA, "F");
    // bad first digit, then the rest of the chunk is dropped
    push_item(qbd_pkg::OP_DATA, qbd_pkg::ChEquals);
    push_item(qbd_pkg::OP_DATA, "G");
    push_item(qbd_pkg::OP_DATA, "x");
    push_item(qbd_pkg::OP_DATA, "B");
    push_item(qbd_pkg::OP_DATA, qbd_pkg::EndByteReset);
    // delimiter inside an escape, then an empty chunk
    push_item(qbd_pkg::OP_DATA, qbd_pkg::ChEquals);
    push_item(qbd_pkg::OP_DATA, qbd_pkg::EndByteReset);
    push_item(qbd_pkg::OP_DATA, qbd_pkg::EndByteReset);
    push_item(qbd_pkg::OP_FLUSH, 8'hff);
    wait_idle();

    // B mode: a full quartet, padding skipped, the two top symbols
    write_reg(qbd_pkg::CfgDecodeMode, 8'd1);
    push_item(qbd_pkg::OP_DATA, "T");
    push_item(qbd_pkg::OP_DATA, "W");
    push_item(qbd_pkg::OP_DATA, "F");
    push_item(qbd_pkg::OP_DATA, "u");
    push_item(qbd_pkg::OP_DATA, qbd_pkg::ChEquals);
    push_item(qbd_pkg::OP_DATA, "/");
    push_item(qbd_pkg::OP_DATA, "+");
    push_item(qbd_pkg::OP_DATA, qbd_pkg::EndByteReset);
    push_item(qbd_pkg::OP_FLUSH, 8'h00);
    wait_idle();

    base     = queued_cnt;
    phase_no = 0;
    while (queued_cnt - base < 1400) begin
      case (phase_no)
        0:       begin m = 1'b0; d = 8'h00; end
        1:       begin m = 1'b1; d = 8'hff; end
        2:       begin m = 1'b0; d = 8'hff; end
        3:       begin m = 1'b1; d = 8'h00; end
        default: begin
          m = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 5))
            0:       d = 8'h00;
            1:       d = 8'hff;
            2:       d = qbd_pkg::EndByteReset;
            3:       d = qbd_pkg::ChEquals;
            4:       d = qbd_pkg::ChNewline;
            default: d = 8'($urandom_range(0, 255));
          endcase
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        write_reg(qbd_pkg::CfgEndByte, d);
        write_reg(qbd_pkg::CfgDecodeMode, {7'd0, m});
      end else begin
        write_reg(qbd_pkg::CfgDecodeMode, {7'd0, m});
        write_reg(qbd_pkg::CfgEndByte, d);
      end
      // stall the receiver for a long stretch while the sender keeps going
      if (phase_no == 0) rx_hold_req = 1'b1;
      repeat ($urandom_range(6, 14)) begin
        if (mode_b64) b_chunk($urandom_range(0, 16));
        else q_chunk($urandom_range(0, 16));
      end
      wait_idle();
      phase_no++;
    end

    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/qbd_pkg.sv
rtl/core/qbd_decode.sv
rtl/core/qbd_out_reg.sv
rtl/core/qp_and_base64_chunk_decoder.sv
tb/tb.sv
